### src/cleb_pkg.sv
// cleb_pkg: shared types and constants for the line edit buffer.
// Holds the command codes, sequencer states and the result record.
// No dependencies.
package cleb_pkg;

  localparam int unsigned CHAR_W = 7;

  localparam logic [7:0] KEY_LO = 8'h20;
  localparam logic [7:0] KEY_HI = 8'h7e;

  localparam logic [5:0] MAX_LENGTH_RST = 6'd63;

  typedef enum logic [2:0] {
    MODE_HOME  = 3'd0,
    MODE_END   = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_TYPE  = 3'd4,
    MODE_ERASE = 3'd5,
    MODE_PRINT = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MV_CHK,
    S_MV_WR,
    S_PL_RD,
    S_PL_EM,
    S_PR_SEP,
    S_PR_RD,
    S_PR_EM
  } seq_state_e;

  typedef struct packed {
    logic       accepted;
    logic       char_valid;
    logic [7:0] out_char;
    logic       last;
  } cleb_res_t;

endpackage

### src/cleb_store.sv
// cleb_store: character store of the gap buffer.
// One write port and one read port with registered read data; uses cleb_pkg.
module cleb_store
  import cleb_pkg::*;
#(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned IW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic [IW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem_q [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/cleb_seq.sv
// cleb_seq: command sequencer of the gap buffer.
// Left part sits at the low end of the store, right part at the high end.
// Depends on cleb_pkg; drives the ports of cleb_store.
module cleb_seq
  import cleb_pkg::*;
#(
  parameter int unsigned CAPACITY = 63,
  parameter int unsigned LW       = 6,
  parameter int unsigned IW       = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        key_char_i,
  input  logic [7:0]        separator_i,
  input  logic [5:0]        limit_i,
  output logic              busy_o,
  output logic              we_o,
  output logic [IW-1:0]     waddr_o,
  output logic [CHAR_W-1:0] wdata_o,
  output logic [IW-1:0]     raddr_o,
  input  logic [CHAR_W-1:0] rdata_i,
  output logic              strobe_o,
  output cleb_res_t         res_o
);

  localparam logic [LW-1:0] CAP = LW'(CAPACITY);
  localparam logic [LW-1:0] ONE = LW'(1);

  seq_state_e    state_q, state_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] rs_q, rs_d;
  logic [LW-1:0] ptr_q, ptr_d;
  logic          dir_left_q, dir_left_d;
  logic          one_shot_q, one_shot_d;
  logic [7:0]    sep_q, sep_d;
  logic          strobe_q, strobe_d;
  cleb_res_t     res_q, res_d;
  logic [LW-1:0] raddr_w, waddr_w;
  logic          key_ok;

  assign key_ok = (key_char_i >= KEY_LO) && (key_char_i <= KEY_HI)
                  && (6'(len_q) < limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      len_q      <= '0;
      rs_q       <= CAP;
      ptr_q      <= '0;
      dir_left_q <= 1'b0;
      one_shot_q <= 1'b0;
      sep_q      <= '0;
      strobe_q   <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      len_q      <= len_d;
      rs_q       <= rs_d;
      ptr_q      <= ptr_d;
      dir_left_q <= dir_left_d;
      one_shot_q <= one_shot_d;
      sep_q      <= sep_d;
      strobe_q   <= strobe_d;
      res_q      <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    len_d      = len_q;
    rs_d       = rs_q;
    ptr_d      = ptr_q;
    dir_left_d = dir_left_q;
    one_shot_d = one_shot_q;
    sep_d      = sep_q;
    strobe_d   = 1'b0;
    res_d      = '0;
    we_o       = 1'b0;
    waddr_w    = '0;
    wdata_o    = '0;
    raddr_w    = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (mode_i)
            MODE_HOME: begin
              dir_left_d = 1'b1;
              one_shot_d = 1'b0;
              state_d    = S_MV_CHK;
            end
            MODE_END: begin
              dir_left_d = 1'b0;
              one_shot_d = 1'b0;
              state_d    = S_MV_CHK;
            end
            MODE_LEFT: begin
              dir_left_d = 1'b1;
              one_shot_d = 1'b1;
              state_d    = S_MV_CHK;
            end
            MODE_RIGHT: begin
              dir_left_d = 1'b0;
              one_shot_d = 1'b1;
              state_d    = S_MV_CHK;
            end
            MODE_TYPE: begin
              strobe_d     = 1'b1;
              res_d.last   = 1'b1;
              if (key_ok) begin
                // the slot at the cursor always lies in the gap
                we_o           = 1'b1;
                waddr_w        = cur_q;
                wdata_o        = key_char_i[CHAR_W-1:0];
                cur_d          = cur_q + ONE;
                len_d          = len_q + ONE;
                res_d.accepted = 1'b1;
              end
            end
            MODE_ERASE: begin
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
              if (cur_q != '0) begin
                cur_d          = cur_q - ONE;
                len_d          = len_q - ONE;
                res_d.accepted = 1'b1;
              end
            end
            MODE_PRINT: begin
              sep_d   = separator_i;
              ptr_d   = '0;
              state_d = S_PL_RD;
            end
            default: begin
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
            end
          endcase
        end
      end

      S_MV_CHK: begin
        if (dir_left_q ? (cur_q == '0) : (rs_q == CAP)) begin
          strobe_d       = 1'b1;
          res_d.accepted = 1'b1;
          res_d.last     = 1'b1;
          state_d        = S_IDLE;
        end else begin
          raddr_w = dir_left_q ? (cur_q - ONE) : rs_q;
          state_d = S_MV_WR;
        end
      end

      S_MV_WR: begin
        // carry one character across the gap
        we_o    = 1'b1;
        wdata_o = rdata_i;
        if (dir_left_q) begin
          waddr_w = rs_q - ONE;
          cur_d   = cur_q - ONE;
          rs_d    = rs_q - ONE;
        end else begin
          waddr_w = cur_q;
          cur_d   = cur_q + ONE;
          rs_d    = rs_q + ONE;
        end
        if (one_shot_q) begin
          strobe_d       = 1'b1;
          res_d.accepted = 1'b1;
          res_d.last     = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_MV_CHK;
        end
      end

      S_PL_RD: begin
        if (ptr_q < cur_q) begin
          raddr_w = ptr_q;
          state_d = S_PL_EM;
        end else begin
          state_d = S_PR_SEP;
        end
      end

      S_PL_EM: begin
        strobe_d         = 1'b1;
        res_d.accepted   = 1'b1;
        res_d.char_valid = 1'b1;
        res_d.out_char   = {1'b0, rdata_i};
        res_d.last       = ((ptr_q + ONE) == cur_q) && (sep_q == '0) && (rs_q == CAP);
        ptr_d            = ptr_q + ONE;
        state_d          = S_PL_RD;
      end

      S_PR_SEP: begin
        if (sep_q != '0) begin
          strobe_d         = 1'b1;
          res_d.accepted   = 1'b1;
          res_d.char_valid = 1'b1;
          res_d.out_char   = sep_q;
          res_d.last       = (rs_q == CAP);
        end else if (len_q == '0) begin
          strobe_d       = 1'b1;
          res_d.accepted = 1'b1;
          res_d.last     = 1'b1;
        end
        ptr_d   = rs_q;
        state_d = S_PR_RD;
      end

      S_PR_RD: begin
        if (ptr_q < CAP) begin
          raddr_w = ptr_q;
          state_d = S_PR_EM;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_PR_EM: begin
        strobe_d         = 1'b1;
        res_d.accepted   = 1'b1;
        res_d.char_valid = 1'b1;
        res_d.out_char   = {1'b0, rdata_i};
        res_d.last       = ((ptr_q + ONE) == CAP);
        ptr_d            = ptr_q + ONE;
        state_d          = S_PR_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != S_IDLE);
  assign waddr_o  = waddr_w[IW-1:0];
  assign raddr_o  = raddr_w[IW-1:0];
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

### src/cursor_line_edit_buffer.sv
// cursor_line_edit_buffer: one-line text editor with a cursor, built as a gap buffer.
// Top level: max_length register, limit in force, cleb_seq and cleb_store.
// Depends on cleb_pkg, cleb_seq and cleb_store.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+-------------------------------
//  command   | start_i, busy_o, mode_i, key_char_i,      | edge with start_i high and
//            | separator_i                               | busy_o low
//  result    | res_strobe_o, accepted_o, char_valid_o,   | edge ending the cycle in which
//            | out_char_o, last_o                        | res_strobe_o is high
//  config    | cfg_we_i, cfg_data_i                      | edge with cfg_we_i high
//
// Type, erase and an unused mode finish at the transfer, busy_o stays low and the
// result shows in the next cycle. Left and right carry at most one character across
// the cursor, home and end every character on one side of it, and print reads every
// character; busy_o stays high meanwhile and store reads go through registered data.
// Reset clears line length and cursor at once; the store needs no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle.
module cursor_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int unsigned CAPACITY = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] key_char_i,
  input  logic [7:0] separator_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i,
  output logic       res_strobe_o,
  output logic       accepted_o,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       last_o
);

  // counters hold 0..CAPACITY, store addresses 0..CAPACITY-1
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [5:0]        max_length_q;
  logic [5:0]        limit;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [IW-1:0]     raddr;
  logic [CHAR_W-1:0] rdata;
  cleb_res_t         res;

  // hold the length limit; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_data_i;
    end
  end

  // limit in force: the smaller of the register and the capacity
  assign limit = ({1'b0, max_length_q} >= 7'(CAPACITY)) ? 6'(CAPACITY) : max_length_q;

  cleb_seq #(
    .CAPACITY (CAPACITY),
    .LW       (LW),
    .IW       (IW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .key_char_i  (key_char_i),
    .separator_i (separator_i),
    .limit_i     (limit),
    .busy_o      (busy_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .strobe_o    (res_strobe_o),
    .res_o       (res)
  );

  cleb_store #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign accepted_o   = res.accepted;
  assign char_valid_o = res.char_valid;
  assign out_char_o   = res.out_char;
  assign last_o       = res.last;

endmodule

### src/cleb_checker.sv
// cleb_checker: port-level checks for cursor_line_edit_buffer.
// Sees the top-level ports only; bound to the top level below.
module cleb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       res_strobe_o,
  input logic       accepted_o,
  input logic       char_valid_o,
  input logic [7:0] out_char_o,
  input logic       last_o
);

  // a command transfer always leads to work in progress or a result
  a_start_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || res_strobe_o))
    else $error("command transfer produced neither busy nor a result");

  // printed bytes only come from a successful print
  a_char_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && char_valid_o) |-> accepted_o)
    else $error("character item without accepted");

  // an item without a character is always the final one, with a zero byte
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !char_valid_o) |-> (last_o && (out_char_o == 8'h00)))
    else $error("status item not final or carries a byte");

  // no result fields asserted between strobes
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_strobe_o |-> (!last_o && !char_valid_o && !accepted_o))
    else $error("result flags high without strobe");

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .res_strobe_o (res_strobe_o),
  .accepted_o   (accepted_o),
  .char_valid_o (char_valid_o),
  .out_char_o   (out_char_o),
  .last_o       (last_o)
);

### tb/sv/testbench.sv
// testbench: self-checking bench for cursor_line_edit_buffer with a predicting scoreboard.
// Drives commands and max_length writes, and checks every result item in order.
// Depends on cleb_pkg and cursor_line_edit_buffer.
module testbench;
  import cleb_pkg::*;

  localparam int unsigned LINE_CAP   = 63;
  localparam int unsigned SETTLE     = 8;     // quiet cycles after the last result
  localparam int unsigned QUIET_MAX  = 3000;  // cycles with no transfer before giving up
  localparam logic [2:0]  MODE_SPARE = 3'd7;  // unused command code

  // Scoreboard: keeps its own copy of the line, cursor and limit, and a queue of the
  // result items each command is due to produce.
  class edit_line_scoreboard;
    logic [CHAR_W-1:0] chars [LINE_CAP];
    int unsigned       len;
    int unsigned       cur;
    logic [5:0]        max_len;
    cleb_res_t         due_items [$];
    int unsigned       errors;
    int unsigned       commands;
    int unsigned       results;
    int unsigned       prints;
    int unsigned       refusals;

    function new();
      len      = 0;
      cur      = 0;
      max_len  = MAX_LENGTH_RST;
      errors   = 0;
      commands = 0;
      results  = 0;
      prints   = 0;
      refusals = 0;
    endfunction

    function int unsigned pending();
      return due_items.size();
    endfunction

    function void push_item(logic acc, logic vld, logic [7:0] ch, logic fin);
      cleb_res_t item;
      item.accepted   = acc;
      item.char_valid = vld;
      item.out_char   = ch;
      item.last       = fin;
      due_items.push_back(item);
    endfunction

    function void note_command(logic [2:0] m, logic [7:0] key, logic [7:0] sep);
      int unsigned lim;
      int unsigned total;
      int unsigned k;
      logic        acc;
      lim = (max_len < LINE_CAP) ? max_len : LINE_CAP;
      acc = 1'b1;
      commands++;
      case (m)
        MODE_HOME:  cur = 0;
        MODE_END:   cur = len;
        MODE_LEFT:  if (cur > 0) cur--;
        MODE_RIGHT: if (cur < len) cur++;
        MODE_TYPE: begin
          if (key < KEY_LO || key > KEY_HI || len >= lim) begin
            acc = 1'b0;
          end else begin
            for (int unsigned i = len; i > cur; i--) chars[i] = chars[i-1];
            chars[cur] = key[CHAR_W-1:0];
            cur++;
            len++;
          end
        end
        MODE_ERASE: begin
          if (cur == 0) begin
            acc = 1'b0;
          end else begin
            for (int unsigned i = cur - 1; i + 1 < len; i++) chars[i] = chars[i+1];
            cur--;
            len--;
          end
        end
        MODE_PRINT: begin
          // Walk the line; the marker goes before the character at the cursor.
          prints++;
          total = len + ((sep != 8'd0) ? 1 : 0);
          k = 0;
          for (int unsigned i = 0; i <= len; i++) begin
            if (i == cur && sep != 8'd0) begin
              k++;
              push_item(1'b1, 1'b1, sep, k == total);
            end
            if (i < len) begin
              k++;
              push_item(1'b1, 1'b1, {1'b0, chars[i]}, k == total);
            end
          end
          if (total == 0) push_item(1'b1, 1'b0, 8'd0, 1'b1);
          return;
        end
        default: acc = 1'b0;
      endcase
      if (!acc) refusals++;
      push_item(acc, 1'b0, 8'd0, 1'b1);
    endfunction

    function void check_result(cleb_res_t got);
      cleb_res_t want;
      results++;
      if (due_items.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, got acc %0b vld %0b char %02h last %0b",
                 $time, got.accepted, got.char_valid, got.out_char, got.last);
        return;
      end
      want = due_items.pop_front();
      if (got.accepted !== want.accepted) begin
        errors++;
        $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, got.accepted);
      end
      if (got.char_valid !== want.char_valid) begin
        errors++;
        $display("%0t: char_valid expected %0b actual %0b", $time, want.char_valid,
                 got.char_valid);
      end
      if (got.out_char !== want.out_char) begin
        errors++;
        $display("%0t: out_char expected %02h actual %02h", $time, want.out_char, got.out_char);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [2:0] mode_i;
  logic [7:0] key_char_i;
  logic [7:0] separator_i;
  logic       cfg_we_i;
  logic [5:0] cfg_data_i;
  logic       res_strobe_o;
  logic       accepted_o;
  logic       char_valid_o;
  logic [7:0] out_char_o;
  logic       last_o;

  edit_line_scoreboard sb;
  bit                  idle_en;
  int unsigned         quiet_cycles;

  cursor_line_edit_buffer #(
    .CAPACITY(LINE_CAP)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .key_char_i  (key_char_i),
    .separator_i (separator_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .accepted_o  (accepted_o),
    .char_valid_o(char_valid_o),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Monitor: note each command transfer, check each strobed result, and run the watchdog.
  // Note before check so that ordering within one edge never matters to the queue.
  always @(posedge clk_i) begin
    cleb_res_t seen;
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_command(mode_i, key_char_i, separator_i);
      if (res_strobe_o) begin
        seen.accepted   = accepted_o;
        seen.char_valid = char_valid_o;
        seen.out_char   = out_char_o;
        seen.last       = last_o;
        sb.check_result(seen);
      end
      if ((start_i && !busy_o) || res_strobe_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: watchdog expired with %0d result items outstanding", $time,
                 sb.pending());
        $display("cursor_line_edit_buffer: mismatch");
        $finish;
      end
    end
  end

  // Present one command from a falling edge and hold it until the block takes it.
  // Idle cycles, when enabled, hold start low ahead of the command.
  task automatic issue(input logic [2:0] m, input logic [7:0] key, input logic [7:0] sep);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    mode_i      <= m;
    key_char_i  <= key;
    separator_i <= sep;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and hold off until every due result has arrived and the block is idle.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0 || busy_o) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Write the length limit only once the block has gone quiet.
  task automatic set_max_length(input logic [5:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.max_len = value;
  endtask

  function automatic logic [7:0] pick_sep();
    return ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_key();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(KEY_LO, KEY_HI))
                                     : 8'($urandom_range(0, 255));
  endfunction

  // Random mix of commands; weights in percent for type and erase, the rest spread
  // over moves, prints and the odd unused code.
  task automatic run_mix(input int unsigned n, input int unsigned type_w,
                         input int unsigned erase_w);
    int unsigned r;
    logic [2:0]  m;
    for (int unsigned j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < type_w) begin
        m = MODE_TYPE;
      end else if (r < type_w + erase_w) begin
        m = MODE_ERASE;
      end else begin
        case ($urandom_range(15))
          0:        m = MODE_HOME;
          1:        m = MODE_END;
          2, 3, 4:  m = MODE_LEFT;
          5, 6, 7:  m = MODE_RIGHT;
          14:       m = MODE_SPARE;
          15:       m = MODE_LEFT;
          default:  m = MODE_PRINT;
        endcase
      end
      issue(m, pick_key(), pick_sep());
    end
  endtask

  // Type printable text up to the limit, with cursor moves sprinkled in so that
  // inserts land mid-line, then push past the limit and print the full line.
  task automatic fill_line();
    while (sb.len < sb.max_len) begin
      case ($urandom_range(19))
        0:       issue(MODE_LEFT, pick_key(), pick_sep());
        1:       issue(MODE_HOME, pick_key(), pick_sep());
        2:       issue(MODE_RIGHT, pick_key(), pick_sep());
        default: issue(MODE_TYPE, 8'($urandom_range(KEY_LO, KEY_HI)), 8'd0);
      endcase
    end
    issue(MODE_TYPE, 8'($urandom_range(KEY_LO, KEY_HI)), 8'd0);
    issue(MODE_TYPE, 8'($urandom_range(KEY_LO, KEY_HI)), 8'd0);
    issue(MODE_PRINT, 8'd0, 8'($urandom_range(1, 255)));
  endtask

  initial begin
    sb           = new();
    idle_en      = 1'b1;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    mode_i       = MODE_HOME;
    key_char_i   = 8'd0;
    separator_i  = 8'd0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = 6'd0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty line, refusals, key range edges, marker placement, spare code.
    issue(MODE_PRINT, 8'h00, 8'h00);   // empty print, no marker
    issue(MODE_PRINT, 8'h00, 8'hff);   // empty print, marker only
    issue(MODE_ERASE, 8'h00, 8'h00);   // erase at the start is refused
    issue(MODE_LEFT,  8'h00, 8'h00);
    issue(MODE_RIGHT, 8'h00, 8'h00);
    issue(MODE_HOME,  8'h00, 8'h00);
    issue(MODE_END,   8'h00, 8'h00);
    issue(MODE_TYPE,  8'h1f, 8'h00);   // just below the printable range
    issue(MODE_TYPE,  8'h7f, 8'h00);   // just above it
    issue(MODE_TYPE,  8'h00, 8'h00);
    issue(MODE_TYPE,  8'hff, 8'h00);
    issue(MODE_TYPE,  8'h20, 8'h00);
    issue(MODE_TYPE,  8'h7e, 8'h00);
    issue(MODE_TYPE,  8'h62, 8'h00);
    issue(MODE_HOME,  8'h00, 8'h00);
    issue(MODE_TYPE,  8'h61, 8'h00);   // insert at the head of the line
    issue(MODE_RIGHT, 8'h00, 8'h00);
    issue(MODE_PRINT, 8'h00, 8'h7c);   // marker mid-line
    issue(MODE_PRINT, 8'h00, 8'h00);
    issue(MODE_END,   8'h00, 8'h00);
    issue(MODE_RIGHT, 8'h00, 8'h00);   // right at the end stays put
    issue(MODE_PRINT, 8'h00, 8'h80);   // marker after the last character
    issue(MODE_ERASE, 8'h00, 8'h00);
    issue(MODE_LEFT,  8'h00, 8'h00);
    issue(MODE_ERASE, 8'h00, 8'h00);   // erase mid-line
    issue(MODE_SPARE, 8'hff, 8'hff);
    issue(MODE_PRINT, 8'h00, 8'h01);

    // Random phases over several limits: zero, one, full, lowered below the length.
    set_max_length(6'd0);
    run_mix(10, 60, 10);
    set_max_length(6'd1);
    run_mix(12, 50, 20);
    set_max_length(6'd63);
    fill_line();
    set_max_length(6'd10);
    run_mix(15, 40, 35);

    // Back-to-back stretch with a random limit, a full pause half way through.
    set_max_length(6'($urandom_range(1, 62)));
    idle_en = 1'b0;
    run_mix(12, 45, 20);
    drain();
    run_mix(12, 45, 20);
    idle_en = 1'b1;

    set_max_length(6'd63);
    run_mix(8, 45, 15);

    drain();
    $display("ran %0d commands (%0d prints, %0d refused), checked %0d result items",
             sb.commands, sb.prints, sb.refusals, sb.results);
    $display("limits covered: 0, 1, 10, 63 and one random value; %0d field errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("cursor_line_edit_buffer: match");
    end else begin
      $display("cursor_line_edit_buffer: mismatch");
    end
    $finish;
  end

endmodule

### files.f
src/cleb_pkg.sv
src/cleb_store.sv
src/cleb_seq.sv
src/cursor_line_edit_buffer.sv
src/cleb_checker.sv
tb/sv/testbench.sv
